FILE: sv/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and helpers of the UV-sphere cell vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // quotient bits produced by the phase divider, one per stage
   localparam int DIV_STEPS = 33;
   localparam int SIN_LAT   = 8;
   localparam int NORM_LAT  = 1;
   localparam int SCALE_LAT = 3;
   localparam int META_LAT  = DIV_STEPS + SIN_LAT + NORM_LAT + SCALE_LAT;

   localparam int CSR_AW = 5;

   localparam logic [2:0]  CORNER_LAST = 3'd5;
   localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

   // odd Taylor-style coefficients of the quarter-wave sine, Q30
   localparam logic [30:0] SIN_C1  = 31'd1686629713;
   localparam logic [30:0] SIN_C3  = 31'd693598669;
   localparam logic [30:0] SIN_C5  = 31'd85569304;
   localparam logic [30:0] SIN_C7  = 31'd5026995;
   localparam logic [30:0] SIN_C9  = 31'd172272;
   localparam logic [30:0] Q30_ONE = 31'd1073741824;

   typedef enum logic [2:0] {
      REG_CENTER_X    = 3'd0,
      REG_CENTER_Y    = 3'd1,
      REG_CENTER_Z    = 3'd2,
      REG_RADIUS      = 3'd3,
      REG_GRID_POINTS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic       err;
      logic       last;
      logic [2:0] corner;
   } meta_type;

   typedef struct packed {
      logic [9:0] ki;   // polar grid index
      logic [9:0] kj;   // twice the azimuth grid index
      meta_type   meta;
   } op_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic [30:0] x;
      logic [30:0] x2;
      logic [30:0] v;
   } sin_stage_type;

   function automatic logic corner_dx(input logic [2:0] c);
      case (c)
         3'd1, 3'd3, 3'd4: corner_dx = 1'b1;
         default:          corner_dx = 1'b0;
      endcase
   endfunction

   function automatic logic corner_dy(input logic [2:0] c);
      case (c)
         3'd2, 3'd4, 3'd5: corner_dy = 1'b1;
         default:          corner_dy = 1'b0;
      endcase
   endfunction

   // (a * b) >> 30, operands and result below 2^31
   function automatic logic [30:0] mul30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b);
      mul30 = p[60:30];
   endfunction

endpackage

FILE: sv/uvs_seq.sv
// ----------------------------------------------------------------------------
// uvs_seq
// Takes cell items, range-checks them and issues one vertex op per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module uvs_seq import uvs_pkg::*; #(
   parameter int NW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    cell_col,
   input  logic [7:0]    cell_row,
   input  logic [NW-1:0] n_eff,
   output logic          op_valid,
   output op_type        op
);

   logic          busy_ff;
   logic          err_ff;
   logic [7:0]    col_ff;
   logic [7:0]    row_ff;
   logic [2:0]    cnt_ff;
   logic          op_valid_ff;
   op_type        op_ff;
   op_type        op_in;
   logic          done;
   logic          accept;
   logic          err_in;

   assign done       = err_ff || (cnt_ff == CORNER_LAST);
   assign req_tready = !busy_ff || (adv && done);
   assign accept     = req_tvalid && req_tready;

   assign err_in = (n_eff < NW'(2)) || (NW'(cell_col) + NW'(2) > n_eff) ||
                   (NW'(cell_row) + NW'(2) > n_eff);

   always_comb begin
      op_in.ki          = 10'(col_ff) + 10'(corner_dx(cnt_ff));
      op_in.kj          = (10'(row_ff) + 10'(corner_dy(cnt_ff))) << 1;
      op_in.meta.err    = err_ff;
      op_in.meta.last   = done;
      op_in.meta.corner = err_ff ? 3'd0 : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         op_valid_ff <= 1'b0;
         cnt_ff      <= 3'd0;
      end else begin
         if (adv) begin
            op_valid_ff <= busy_ff;
            if (busy_ff) begin
               if (done) begin
                  busy_ff <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
         end
         if (accept) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= op_in;
      end
      if (accept) begin
         col_ff <= cell_col;
         row_ff <= cell_row;
         err_ff <= err_in;
      end
   end

   assign op_valid = op_valid_ff;
   assign op       = op_ff;

endmodule

FILE: sv/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: phase = floor((k*2^31 + half) / d) mod 2^32.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [9:0]    k,
   input  logic [DW-1:0] d,
   input  logic [30:0]   half,
   output logic [31:0]   phase
);

   logic [DW-1:0] rem_ff  [DIV_STEPS];
   logic [DW-1:0] rem_in  [DIV_STEPS];
   logic [32:0]   bits_ff [DIV_STEPS];
   logic [32:0]   bits_in [DIV_STEPS];
   logic [31:0]   q_ff    [DIV_STEPS];
   logic [31:0]   q_in    [DIV_STEPS];

   always_comb begin
      logic [DW-1:0] r_prev;
      logic [32:0]   b_prev;
      logic [31:0]   q_prev;
      logic [DW:0]   t;
      logic          ge;
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            r_prev = DW'(k >> 2);
            b_prev = {k[1:0], half};
            q_prev = 32'd0;
         end else begin
            r_prev = rem_ff[s-1];
            b_prev = bits_ff[s-1];
            q_prev = q_ff[s-1];
         end
         t          = {r_prev, b_prev[32]};
         ge         = t >= {1'b0, d};
         rem_in[s]  = ge ? DW'(t - {1'b0, d}) : DW'(t);
         bits_in[s] = b_prev << 1;
         q_in[s]    = {q_prev[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            q_ff[s]    <= q_in[s];
         end
      end
   end

   assign phase = q_ff[DIV_STEPS-1];

endmodule

FILE: sv/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine
// Pipelined Q16 sine of a 32-bit phase, odd polynomial by Horner steps.
// ----------------------------------------------------------------------------
module uvs_sine import uvs_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic        [31:0] phase,
   output logic signed [17:0] sine
);

   sin_stage_type      st_ff [SIN_LAT-1];
   sin_stage_type      st_in [SIN_LAT-1];
   logic signed [17:0] s_ff;
   logic signed [17:0] s_in;

   always_comb begin
      logic [30:0] q;
      logic [31:0] rnd;
      logic [17:0] mag;
      q              = {1'b0, phase[29:0]};
      st_in[0].quad  = phase[31:30];
      st_in[0].x     = phase[30] ? (Q30_ONE - q) : q;
      st_in[0].x2    = 31'd0;
      st_in[0].v     = 31'd0;
      for (int k = 1; k < SIN_LAT - 1; k++) begin
         st_in[k] = st_ff[k-1];
      end
      st_in[1].x2 = mul30(st_ff[0].x, st_ff[0].x);
      st_in[2].v  = SIN_C7 - mul30(st_ff[1].x2, SIN_C9);
      st_in[3].v  = SIN_C5 - mul30(st_ff[2].x2, st_ff[2].v);
      st_in[4].v  = SIN_C3 - mul30(st_ff[3].x2, st_ff[3].v);
      st_in[5].v  = SIN_C1 - mul30(st_ff[4].x2, st_ff[4].v);
      st_in[6].v  = mul30(st_ff[5].x, st_ff[5].v);

      rnd = 32'(st_ff[6].v) + 32'd8192;
      mag = 18'(rnd >> 14);
      if (mag > 18'd65536) begin
         mag = 18'd65536;
      end
      s_in = st_ff[6].quad[1] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SIN_LAT - 1; k++) begin
            st_ff[k] <= st_in[k];
         end
         s_ff <= s_in;
      end
   end

   assign sine = s_ff;

endmodule

FILE: sv/uvs_scale.sv
// ----------------------------------------------------------------------------
// uvs_scale
// Coordinate = sat32(center + round(radius * n / 2^32)), n a Q32 component.
// ----------------------------------------------------------------------------
module uvs_scale import uvs_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [33:0] n,
   input  logic        [30:0] radius,
   input  logic signed [31:0] center,
   output logic signed [31:0] coord
);

   logic               neg_ff;
   logic               m32_ff;
   logic        [62:0] p_ff;
   logic signed [32:0] o_ff;
   logic signed [31:0] c_ff;

   logic        [33:0] m_in;
   logic        [63:0] p2;
   logic        [31:0] r;
   logic signed [32:0] o_in;
   logic signed [33:0] sum;
   logic signed [31:0] c_in;

   always_comb begin
      m_in = n[33] ? 34'(-n) : 34'(n);
      p2   = 64'(p_ff) + (m32_ff ? {1'b0, radius, 32'd0} : 64'd0) + 64'h8000_0000;
      r    = p2[63:32];
      o_in = neg_ff ? -$signed({1'b0, r}) : $signed({1'b0, r});
      sum  = 34'(center) + 34'(o_ff);
      if (sum > 34'sd2147483647) begin
         c_in = 32'sh7FFF_FFFF;
      end else if (sum < -34'sd2147483648) begin
         c_in = 32'sh8000_0000;
      end else begin
         c_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= n[33];
         m32_ff <= m_in[32];
         p_ff   <= 63'(radius) * 63'(m_in[31:0]);
         o_ff   <= o_in;
         c_ff   <= c_in;
      end
   end

   assign coord = c_ff;

endmodule

FILE: sv/uv_sphere_cell_vertex_gen_unit.sv
// ----------------------------------------------------------------------------
// uv_sphere_cell_vertex_gen_unit
// Emits the six vertices of one UV-sphere grid cell, Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Each accepted cell item yields six vertex items, one per cycle while the
// pipeline advances, in the order (x,y) (x+1,y) (x,y+1) (x+1,y) (x+1,y+1)
// (x,y+1); tlast marks the sixth. A cell with an index above N-2 (or N below
// 2) yields one item with zero coordinates, tuser (cell_error) set and tlast
// set. A new cell is taken as the last vertex of the current one is issued:
// the vertex sequencer issues one vertex per cycle into the pipeline while it
// advances. The first vertex passes through the sequencer, the 33-stage phase
// divider, the 8-stage sine, the normal product, the 3-stage scale and the
// output register. The whole pipeline advances together; it holds while the
// output item waits for rsp_tready. Configure only while idle.
// ----------------------------------------------------------------------------
module uv_sphere_cell_vertex_gen_unit import uvs_pkg::*; #(
   parameter int MAX_POINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   // input items
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // cell_col[7:0], cell_row[15:8]
   // result items
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [103:0]        rsp_tdata,   // vert_x, vert_y, vert_z, corner, zero pad
   output logic                rsp_tuser,   // cell_error
   output logic                rsp_tlast,
   // configuration
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int NW = ($clog2(MAX_POINTS + 1) > 9) ? $clog2(MAX_POINTS + 1) : 9;
   localparam int DW = ($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) : 1;

   // configuration registers
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic        [30:0] radius_ff;
   logic        [8:0]  grid_points_ff;

   logic               csr_wr;
   reg_index_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= 32'sd0;
         center_y_ff    <= 32'sd0;
         center_z_ff    <= 32'sd0;
         radius_ff      <= 31'd65536;
         grid_points_ff <= 9'd16;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CENTER_X:    center_x_ff    <= csr_pwdata;
            REG_CENTER_Y:    center_y_ff    <= csr_pwdata;
            REG_CENTER_Z:    center_z_ff    <= csr_pwdata;
            REG_RADIUS:      radius_ff      <= csr_pwdata[30:0];
            REG_GRID_POINTS: grid_points_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CENTER_X:    csr_prdata = center_x_ff;
         REG_CENTER_Y:    csr_prdata = center_y_ff;
         REG_CENTER_Z:    csr_prdata = center_z_ff;
         REG_RADIUS:      csr_prdata = {1'b0, radius_ff};
         REG_GRID_POINTS: csr_prdata = {23'd0, grid_points_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // effective N, divisor d = N-1 and rounding term floor(d/2)
   logic [NW-1:0] n_eff;
   logic [DW-1:0] div_d;
   logic [30:0]   div_half;

   assign n_eff    = (NW'(grid_points_ff) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                             : NW'(grid_points_ff);
   assign div_d    = DW'(n_eff - NW'(1));
   assign div_half = 31'(div_d >> 1);

   // global advance: everything moves unless the output item is stuck
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;

   logic   op_valid;
   op_type op;

   uvs_seq #(.NW(NW)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cell_col   (req_tdata[7:0]),
      .cell_row   (req_tdata[15:8]),
      .n_eff      (n_eff),
      .op_valid   (op_valid),
      .op         (op)
   );

   // metadata travels beside the datapath
   logic     mvalid_ff [META_LAT];
   meta_type meta_ff   [META_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < META_LAT; s++) begin
            mvalid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         mvalid_ff[0] <= op_valid;
         for (int s = 1; s < META_LAT; s++) begin
            mvalid_ff[s] <= mvalid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= op.meta;
         for (int s = 1; s < META_LAT; s++) begin
            meta_ff[s] <= meta_ff[s-1];
         end
      end
   end

   // polar and azimuth phases
   logic [31:0] phase_a, phase_b;

   uvs_div #(.DW(DW)) u_div_a (
      .clock (clock), .adv (adv), .k (op.ki), .d (div_d), .half (div_half),
      .phase (phase_a)
   );

   uvs_div #(.DW(DW)) u_div_b (
      .clock (clock), .adv (adv), .k (op.kj), .d (div_d), .half (div_half),
      .phase (phase_b)
   );

   // four sines; cosine is the sine a quarter turn ahead
   logic signed [17:0] sin_a, cos_a, sin_b, cos_b;

   uvs_sine u_sin_a (.clock (clock), .adv (adv), .phase (phase_a), .sine (sin_a));
   uvs_sine u_cos_a (.clock (clock), .adv (adv), .phase (phase_a + PHASE_QUARTER),
                     .sine (cos_a));
   uvs_sine u_sin_b (.clock (clock), .adv (adv), .phase (phase_b), .sine (sin_b));
   uvs_sine u_cos_b (.clock (clock), .adv (adv), .phase (phase_b + PHASE_QUARTER),
                     .sine (cos_b));

   // unit normal in Q32
   logic signed [33:0] nx_ff, ny_ff, nz_ff;
   logic signed [35:0] nx_full, nz_full;

   assign nx_full = sin_a * sin_b;
   assign nz_full = sin_a * cos_b;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_full[33:0];
         ny_ff <= {cos_a, 16'd0};
         nz_ff <= nz_full[33:0];
      end
   end

   logic signed [31:0] vx, vy, vz;

   uvs_scale u_scale_x (.clock (clock), .adv (adv), .n (nx_ff), .radius (radius_ff),
                        .center (center_x_ff), .coord (vx));
   uvs_scale u_scale_y (.clock (clock), .adv (adv), .n (ny_ff), .radius (radius_ff),
                        .center (center_y_ff), .coord (vy));
   uvs_scale u_scale_z (.clock (clock), .adv (adv), .n (nz_ff), .radius (radius_ff),
                        .center (center_z_ff), .coord (vz));

   // output register; rejected cells report zero coordinates
   logic          rsp_valid_ff;
   logic [103:0]  rsp_data_ff;
   logic          rsp_err_ff;
   logic          rsp_last_ff;
   meta_type      mt;

   assign mt = meta_ff[META_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mvalid_ff[META_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (mt.err) begin
            rsp_data_ff <= 104'd0;
         end else begin
            rsp_data_ff <= {5'd0, mt.corner, vz, vy, vx};
         end
         rsp_err_ff  <= mt.err;
         rsp_last_ff <= mt.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
